@@ design/ssd_pkg.sv @@
// Shared types and constants for the seven segment scan driver.
// No dependencies; imported by the driver core and its checker.
`default_nettype none

package ssd_pkg;

	localparam int VALUE_W     = 24;
	localparam int SEC_W       = 8;
	localparam int DIGIT_W     = 4;
	localparam int POS_W       = 3;
	localparam int SLOT_W      = 3;
	localparam int REFRESH_W   = 16;
	localparam int SEG_W       = 8;
	localparam int DIGLINE_W   = 4;
	localparam int STATUS_W    = 3;
	localparam int OPCODE_W    = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int RATE_W      = 8;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [1:0]          run_mode_t;

	localparam opcode_t OP_TICK  = 2'd0;
	localparam opcode_t OP_LOAD  = 2'd1;
	localparam opcode_t OP_DIGIT = 2'd2;

	localparam run_mode_t MODE_IDLE   = 2'd0;
	localparam run_mode_t MODE_VALUE  = 2'd1;
	localparam run_mode_t MODE_SINGLE = 2'd2;

	localparam status_t STATUS_NONE     = 3'd0;
	localparam status_t STATUS_ACCEPTED = 3'd1;
	localparam status_t STATUS_RANGE    = 3'd2;
	localparam status_t STATUS_REFUSED  = 3'd3;
	localparam status_t STATUS_FINISHED = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_POLARITY   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_TICKS = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RATE       = 2'd2;

	localparam logic [CFG_DATA_W-1:0] SLOT_TICKS_RST = 24'd700;
	localparam logic [RATE_W-1:0]     RATE_RST       = 8'd50;

	localparam logic [VALUE_W-1:0] MAX_THOUSANDTHS = 24'd9999000;
	localparam logic [VALUE_W-1:0] INT_2DIGITS     = 24'd10000;
	localparam logic [VALUE_W-1:0] INT_3DIGITS     = 24'd100000;
	localparam logic [VALUE_W-1:0] INT_4DIGITS     = 24'd1000000;

	localparam logic [DIGIT_W-1:0] DIGIT_POINT = 4'd10;
	localparam logic [SEG_W-1:0]   POINT_MASK  = 8'h80;

	// divide by ten: q = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x < 2^CONV_W
	localparam int                CONV_W      = 27;
	localparam logic [CONV_W-1:0] DIV10_MUL   = 27'd107374183;
	localparam int                DIV10_SHIFT = 30;

	// segment lit in each slot of a digit; slot 0 in the low byte
	function automatic logic [SEG_W-1:0] seg_mask(logic [DIGIT_W-1:0] d, logic [SLOT_W-1:0] s);
		logic [55:0] row;
		row = 56'h0;
		unique case (d)
			4'd0:    row = 56'h00_20_10_08_04_02_01;
			4'd1:    row = 56'h00_00_00_00_00_04_02;
			4'd2:    row = 56'h00_00_08_10_40_02_01;
			4'd3:    row = 56'h00_00_08_04_40_02_01;
			4'd4:    row = 56'h00_00_00_04_02_40_20;
			4'd5:    row = 56'h00_00_08_04_40_20_01;
			4'd6:    row = 56'h00_10_08_04_40_20_01;
			4'd7:    row = 56'h00_00_00_00_04_02_01;
			4'd8:    row = 56'h40_20_10_08_04_02_01;
			4'd9:    row = 56'h00_40_20_08_04_02_01;
			default: row = 56'h0;
		endcase
		if (s == 3'd7) begin
			return 8'h00;
		end
		return row[8*s +: 8];
	endfunction

endpackage

`default_nettype wire

@@ design/seven_segment_scan_driver_unit.sv @@
// Seven segment scan driver: command decode, scan sequencer, digit conversion.
// Depends on ssd_pkg.
//
// Usage: each input word carries an opcode. A tick word advances time by one
// tick; a load word takes a value in thousandths and starts a display run of
// refreshes_per_second * display_seconds refreshes; a single-digit word shows
// one digit (or the point) for one pass. Every input word yields exactly one
// result word with the pin levels driven during that word, the busy flag
// after it and a status code.
// The result word is registered in the output register in the cycle after the
// input word is taken. Ticks and single-digit words go at one per cycle while
// the receiver does not stall. A load that passes the range check stalls the
// input side while a shared divide-by-ten unit converts the value, one step per
// cycle: zero to three scaling steps plus NUM_DIGITS digit steps.
// Configuration writes land at once on cfg_wr_en; index 3 is ignored.
// Reset: registers return to defaults, no run active, output register empty.
// A stalled receiver holds the result word; a new input word is taken in the
// same cycle the held word leaves.
`default_nettype none

module seven_segment_scan_driver_unit
	import ssd_pkg::*;
#(
	parameter int NUM_DIGITS      = 4,
	parameter int SLOTS_PER_DIGIT = 7,
	parameter int TICK_COUNT_BITS = 24
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_wr_en,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_wdata,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [OPCODE_W-1:0]     opcode,
	input  wire [VALUE_W-1:0]      value_thousandths,
	input  wire [SEC_W-1:0]        display_seconds,
	input  wire [DIGIT_W-1:0]      digit_value,
	input  wire [POS_W-1:0]        digit_position,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [SEG_W-1:0]       segment_lines,
	output logic [DIGLINE_W-1:0]   digit_lines,
	output logic                   busy_res,
	output logic [STATUS_W-1:0]    status
);

	localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int CW     = ((TICK_COUNT_BITS > CFG_DATA_W) ? TICK_COUNT_BITS : CFG_DATA_W) + 1;

	localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_DIGITS - 1);
	localparam logic [3:0]        NUM_D4    = 4'(NUM_DIGITS);
	localparam logic [3:0]        SLOTS4    = 4'(SLOTS_PER_DIGIT);

	localparam logic [1:0] CV_IDLE  = 2'd0;
	localparam logic [1:0] CV_SCALE = 2'd1;
	localparam logic [1:0] CV_DIGIT = 2'd2;

	// configuration
	logic                  polarity_q;
	logic [CFG_DATA_W-1:0] slot_ticks_q;
	logic [RATE_W-1:0]     rate_q;

	// scan state
	logic [DIGIT_W-1:0]         digit_store_q [NUM_DIGITS];
	logic [POS_W-1:0]           point_pos_q;
	logic [SCAN_W-1:0]          scan_digit_q;
	logic [SLOT_W-1:0]          slot_index_q;
	logic [TICK_COUNT_BITS-1:0] tick_count_q;
	logic [REFRESH_W-1:0]       refreshes_left_q;
	run_mode_t                  run_mode_q;
	logic                       point_phase_q;

	// conversion sequencer
	logic [1:0]        conv_state_q;
	logic [CONV_W-1:0] conv_x_q;
	logic [2:0]        conv_cnt_q;
	logic              conv_mul_q;
	logic [SCAN_W-1:0] conv_idx_q;

	// result register
	logic                 out_valid_s1;
	logic [SEG_W-1:0]     seg_s1;
	logic [DIGLINE_W-1:0] dig_s1;
	logic                 busy_s1;
	status_t              status_s1;

	// next-state values
	logic [POS_W-1:0]           nxt_point_pos;
	logic [SCAN_W-1:0]          nxt_scan;
	logic [SLOT_W-1:0]          nxt_slot;
	logic [TICK_COUNT_BITS-1:0] nxt_tick;
	logic [REFRESH_W-1:0]       nxt_refresh;
	run_mode_t                  nxt_mode;
	logic                       nxt_point_phase;
	status_t                    nxt_status;
	logic                       load_start;
	logic                       digit_wr;
	logic [SCAN_W-1:0]          digit_wr_idx;

	logic [DIGIT_W-1:0]   cur_digit;
	logic [SEG_W-1:0]     mask;
	logic                 sel_on;
	logic [2:0]           sel_idx;
	logic [DIGLINE_W-1:0] sel;
	logic [SEG_W-1:0]     seg_w;
	logic [DIGLINE_W-1:0] dig_w;

	logic [CW-1:0]     tc_inc;
	logic [CW-1:0]     limit_w;
	logic [CW-1:0]     cap_w;
	logic [3:0]        slot_inc;
	logic [3:0]        single_len;
	logic [REFRESH_W-1:0] refresh_dec;
	logic [POS_W-1:0]  pos_m1;

	logic [2:0]        int_digits;
	logic [3:0]        frac_room;
	logic              load_point;
	logic [2:0]        scale_cnt;
	logic              scale_mul;

	logic [CONV_W+CONV_W-1:0] div_prod;
	logic [CONV_W-1:0]        div_q;
	logic [CONV_W-1:0]        div_rem;
	logic                     accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (conv_state_q == CV_IDLE) && (!out_valid_s1 || out_ready);

	assign out_valid     = out_valid_s1;
	assign segment_lines = seg_s1;
	assign digit_lines   = dig_s1;
	assign busy_res      = busy_s1;
	assign status        = status_s1;

	// pin levels from the state before the word
	always_comb begin
		cur_digit = digit_store_q[scan_digit_q];
		mask      = '0;
		sel_on    = 1'b0;
		sel_idx   = 3'(scan_digit_q);
		unique case (run_mode_q)
			MODE_VALUE: begin
				if (point_phase_q) begin
					mask    = POINT_MASK;
					sel_on  = (point_pos_q != '0);
					sel_idx = point_pos_q - 3'd1;
				end else begin
					mask   = seg_mask(cur_digit, slot_index_q);
					sel_on = 1'b1;
				end
			end
			MODE_SINGLE: begin
				mask   = (cur_digit == DIGIT_POINT) ? POINT_MASK
				         : seg_mask(cur_digit, slot_index_q);
				sel_on = 1'b1;
			end
			default: begin
				mask   = '0;
				sel_on = 1'b0;
			end
		endcase
		sel = sel_on ? (4'b0001 << sel_idx) : 4'b0000;
		if (polarity_q) begin
			seg_w = ~mask;
			dig_w = sel;
		end else begin
			seg_w = mask;
			dig_w = ~sel;
		end
	end

	// load scaling: integer digit count and the divide or multiply steps
	always_comb begin
		int_digits = 3'd1 + 3'(value_thousandths >= INT_2DIGITS)
		             + 3'(value_thousandths >= INT_3DIGITS)
		             + 3'(value_thousandths >= INT_4DIGITS);
		load_point = ({1'b0, int_digits} < NUM_D4);
		frac_room  = NUM_D4 - {1'b0, int_digits};
		scale_mul  = 1'b0;
		scale_cnt  = 3'd3;
		if (load_point) begin
			if (frac_room > 4'd3) begin
				scale_mul = 1'b1;
				scale_cnt = 3'(frac_room - 4'd3);
			end else begin
				scale_cnt = 3'(4'd3 - frac_room);
			end
		end
	end

	// command decode and scan advance
	always_comb begin
		nxt_point_pos   = point_pos_q;
		nxt_scan        = scan_digit_q;
		nxt_slot        = slot_index_q;
		nxt_tick        = tick_count_q;
		nxt_refresh     = refreshes_left_q;
		nxt_mode        = run_mode_q;
		nxt_point_phase = point_phase_q;
		nxt_status      = STATUS_NONE;
		load_start      = 1'b0;
		digit_wr        = 1'b0;
		pos_m1          = digit_position - 3'd1;
		digit_wr_idx    = pos_m1[SCAN_W-1:0];

		tc_inc  = CW'(tick_count_q) + CW'(1);
		cap_w   = CW'(1) << TICK_COUNT_BITS;
		limit_w = (slot_ticks_q == '0) ? CW'(1) : CW'(slot_ticks_q);
		if (limit_w > cap_w) begin
			limit_w = cap_w;
		end
		slot_inc    = {1'b0, slot_index_q} + 4'd1;
		single_len  = (cur_digit == DIGIT_POINT) ? 4'd1 : SLOTS4;
		refresh_dec = (refreshes_left_q != '0) ? refreshes_left_q - 16'd1 : '0;

		unique case (opcode)
			OP_TICK: begin
				if (run_mode_q != MODE_IDLE) begin
					if (tc_inc < limit_w) begin
						nxt_tick = tc_inc[TICK_COUNT_BITS-1:0];
					end else begin
						nxt_tick = '0;
						if (run_mode_q == MODE_SINGLE) begin
							if (slot_inc >= single_len) begin
								nxt_slot   = '0;
								nxt_mode   = MODE_IDLE;
								nxt_status = STATUS_FINISHED;
							end else begin
								nxt_slot = slot_inc[SLOT_W-1:0];
							end
						end else if (point_phase_q) begin
							nxt_point_phase = 1'b0;
							nxt_scan        = SCAN_LAST;
							nxt_slot        = '0;
						end else if (slot_inc < SLOTS4) begin
							nxt_slot = slot_inc[SLOT_W-1:0];
						end else begin
							nxt_slot = '0;
							if (scan_digit_q != '0) begin
								nxt_scan = scan_digit_q - SCAN_W'(1);
							end else begin
								nxt_refresh = refresh_dec;
								if (refresh_dec == '0) begin
									nxt_mode   = MODE_IDLE;
									nxt_scan   = '0;
									nxt_status = STATUS_FINISHED;
								end else begin
									nxt_point_phase = (point_pos_q != '0);
									nxt_scan        = SCAN_LAST;
								end
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (run_mode_q != MODE_IDLE) begin
					nxt_status = STATUS_REFUSED;
				end else if (value_thousandths > MAX_THOUSANDTHS) begin
					nxt_status = STATUS_RANGE;
				end else begin
					load_start    = 1'b1;
					nxt_point_pos = load_point ? int_digits : '0;
					nxt_refresh   = REFRESH_W'(rate_q) * REFRESH_W'(display_seconds);
					if (nxt_refresh == '0) begin
						nxt_status = STATUS_FINISHED;
					end else begin
						nxt_mode        = MODE_VALUE;
						nxt_point_phase = load_point;
						nxt_scan        = SCAN_LAST;
						nxt_slot        = '0;
						nxt_tick        = '0;
						nxt_status      = STATUS_ACCEPTED;
					end
				end
			end
			OP_DIGIT: begin
				if (run_mode_q != MODE_IDLE) begin
					nxt_status = STATUS_REFUSED;
				end else if (digit_value > DIGIT_POINT || digit_position == '0
				             || {1'b0, digit_position} > NUM_D4) begin
					nxt_status = STATUS_RANGE;
				end else begin
					digit_wr        = 1'b1;
					nxt_scan        = digit_wr_idx;
					nxt_slot        = '0;
					nxt_tick        = '0;
					nxt_point_phase = 1'b0;
					nxt_mode        = MODE_SINGLE;
					nxt_status      = STATUS_ACCEPTED;
				end
			end
			default: begin
				nxt_status = STATUS_NONE;
			end
		endcase
	end

	// shared divide-by-ten unit
	always_comb begin
		div_prod = (CONV_W+CONV_W)'(conv_x_q) * (CONV_W+CONV_W)'(DIV10_MUL);
		div_q    = div_prod[DIV10_SHIFT +: CONV_W];
		div_rem  = conv_x_q - ((div_q << 3) + (div_q << 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q   <= 1'b0;
			slot_ticks_q <= SLOT_TICKS_RST;
			rate_q       <= RATE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POLARITY:   polarity_q   <= cfg_wdata[0];
				REG_SLOT_TICKS: slot_ticks_q <= cfg_wdata;
				REG_RATE:       rate_q       <= cfg_wdata[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_pos_q      <= '0;
			scan_digit_q     <= '0;
			slot_index_q     <= '0;
			tick_count_q     <= '0;
			refreshes_left_q <= '0;
			run_mode_q       <= MODE_IDLE;
			point_phase_q    <= 1'b0;
		end else if (accept) begin
			point_pos_q      <= nxt_point_pos;
			scan_digit_q     <= nxt_scan;
			slot_index_q     <= nxt_slot;
			tick_count_q     <= nxt_tick;
			refreshes_left_q <= nxt_refresh;
			run_mode_q       <= nxt_mode;
			point_phase_q    <= nxt_point_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_store_q[i] <= '0;
			end
			conv_state_q <= CV_IDLE;
			conv_cnt_q   <= '0;
			conv_mul_q   <= 1'b0;
			conv_idx_q   <= '0;
		end else begin
			unique case (conv_state_q)
				CV_IDLE: begin
					if (accept && load_start) begin
						conv_cnt_q   <= scale_cnt;
						conv_mul_q   <= scale_mul;
						conv_idx_q   <= SCAN_LAST;
						conv_state_q <= (scale_cnt == '0) ? CV_DIGIT : CV_SCALE;
					end else if (accept && digit_wr) begin
						digit_store_q[digit_wr_idx] <= digit_value;
					end
				end
				CV_SCALE: begin
					conv_cnt_q <= conv_cnt_q - 3'd1;
					if (conv_cnt_q == 3'd1) begin
						conv_state_q <= CV_DIGIT;
					end
				end
				CV_DIGIT: begin
					digit_store_q[conv_idx_q] <= div_rem[DIGIT_W-1:0];
					conv_idx_q                <= conv_idx_q - SCAN_W'(1);
					if (conv_idx_q == '0) begin
						conv_state_q <= CV_IDLE;
					end
				end
				default: begin
					conv_state_q <= CV_IDLE;
				end
			endcase
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (conv_state_q == CV_IDLE) begin
			if (accept && load_start) begin
				conv_x_q <= CONV_W'(value_thousandths);
			end
		end else if (conv_state_q == CV_SCALE && conv_mul_q) begin
			conv_x_q <= (conv_x_q << 3) + (conv_x_q << 1);
		end else begin
			conv_x_q <= div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1    <= seg_w;
			dig_s1    <= dig_w;
			busy_s1   <= (nxt_mode != MODE_IDLE);
			status_s1 <= nxt_status;
		end
	end

endmodule

`default_nettype wire

@@ design/ssd_checker.sv @@
// Port-level checker for the seven segment scan driver, bound to the top level.
// Depends on ssd_pkg and seven_segment_scan_driver_unit.
`default_nettype none

module ssd_checker
	import ssd_pkg::*;
(
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_ready,
	input wire                   out_valid,
	input wire                   out_ready,
	input wire [SEG_W-1:0]       segment_lines,
	input wire [DIGLINE_W-1:0]   digit_lines,
	input wire                   busy_res,
	input wire [STATUS_W-1:0]    status
);

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segment_lines)
		&& $stable(digit_lines) && $stable(status) && $stable(busy_res))
		else $error("result word changed while stalled");

	// every accepted word shows up in the result register next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("result word missing after accept");

	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FINISHED |-> !busy_res)
		else $error("finished status while still busy");

	a_accepted_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_ACCEPTED || status == STATUS_REFUSED) |-> busy_res)
		else $error("accepted or refused word without busy");

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.segment_lines (segment_lines),
	.digit_lines   (digit_lines),
	.busy_res      (busy_res),
	.status        (status)
);

`default_nettype wire

@@ verif/ssd_checker.sv @@
// Scoreboard for the seven segment scan driver: mirrors the scan sequencer per input word
// and compares every result word against the predicted pin levels, busy flag and status.
// Depends on ssd_pkg; instantiated by tb_seven_segment_scan_driver_unit.
`default_nettype none

module ssd_scoreboard
	import ssd_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_wdata,
	input  wire                  in_valid,
	input  wire                  in_ready,
	input  wire [OPCODE_W-1:0]   opcode,
	input  wire [VALUE_W-1:0]    value_thousandths,
	input  wire [SEC_W-1:0]      display_seconds,
	input  wire [DIGIT_W-1:0]    digit_value,
	input  wire [POS_W-1:0]      digit_position,
	input  wire                  out_valid,
	input  wire                  out_ready,
	input  wire [SEG_W-1:0]      segment_lines,
	input  wire [DIGLINE_W-1:0]  digit_lines,
	input  wire                  busy_res,
	input  wire [STATUS_W-1:0]   status,
	output logic [31:0]          fail_count,
	output logic [31:0]          pending
);

	localparam logic [2:0] DIGITS     = 3'd4;
	localparam logic [1:0] LAST_DIGIT = 2'd3;
	localparam logic [2:0] SLOTS      = 3'd7;
	localparam int         REPORT_MAX = 10;

	typedef struct packed {
		logic [SEG_W-1:0]     seg;
		logic [DIGLINE_W-1:0] dig;
		logic                 busy;
		status_t              st;
	} pin_word_t;

	pin_word_t pin_words[$];

	logic                  pol_q;
	logic [CFG_DATA_W-1:0] slot_ticks_q;
	logic [RATE_W-1:0]     rate_q;
	logic [DIGIT_W-1:0]    digits_q [4];
	logic [2:0]            point_pos_q;
	logic [1:0]            scan_q;
	logic [2:0]            slot_q;
	logic [31:0]           ticks_q;
	logic [REFRESH_W-1:0]  refresh_q;
	run_mode_t             mode_q;
	logic                  point_phase_q;
	int                    errors;

	function automatic logic [SEG_W-1:0] lit_segment(logic [DIGIT_W-1:0] d, logic [2:0] s);
		logic [0:6][7:0] order;
		case (d)
			4'd0:    order = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h00};
			4'd1:    order = {8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			4'd2:    order = {8'h01, 8'h02, 8'h40, 8'h10, 8'h08, 8'h00, 8'h00};
			4'd3:    order = {8'h01, 8'h02, 8'h40, 8'h04, 8'h08, 8'h00, 8'h00};
			4'd4:    order = {8'h20, 8'h40, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00};
			4'd5:    order = {8'h01, 8'h20, 8'h40, 8'h04, 8'h08, 8'h00, 8'h00};
			4'd6:    order = {8'h01, 8'h20, 8'h40, 8'h04, 8'h08, 8'h10, 8'h00};
			4'd7:    order = {8'h01, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
			4'd8:    order = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};
			4'd9:    order = {8'h01, 8'h02, 8'h04, 8'h08, 8'h20, 8'h40, 8'h00};
			default: order = '0;
		endcase
		if (s >= SLOTS) begin
			return 8'h00;
		end
		return order[s];
	endfunction

	function automatic longint unsigned pow10(int n);
		longint unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	task automatic restart_scan();
		point_phase_q = (point_pos_q != 3'd0);
		scan_q = LAST_DIGIT;
		slot_q = 3'd0;
		ticks_q = 32'd0;
	endtask

	// levels come from the state before the word, then the word updates the state
	task automatic predict_pins(input opcode_t op, input logic [VALUE_W-1:0] v,
			input logic [SEC_W-1:0] sec, input logic [DIGIT_W-1:0] dv,
			input logic [POS_W-1:0] pos, output pin_word_t w);
		logic [SEG_W-1:0] mask;
		logic [7:0]       sel;
		logic [31:0]      limit;
		longint unsigned  whole;
		longint unsigned  shown;
		int               k;
		int               i;
		mask = '0;
		sel = '0;
		if (mode_q == MODE_VALUE) begin
			if (point_phase_q) begin
				mask = POINT_MASK;
				sel = (point_pos_q >= 3'd1) ? (8'd1 << (point_pos_q - 3'd1)) : 8'd0;
			end else begin
				mask = lit_segment(digits_q[scan_q], slot_q);
				sel = 8'd1 << scan_q;
			end
		end else if (mode_q == MODE_SINGLE) begin
			mask = (digits_q[scan_q] == DIGIT_POINT) ? POINT_MASK
				: lit_segment(digits_q[scan_q], slot_q);
			sel = 8'd1 << scan_q;
		end
		if (pol_q) begin
			w.seg = ~mask;
			w.dig = sel[3:0];
		end else begin
			w.seg = mask;
			w.dig = ~sel[3:0];
		end
		w.st = STATUS_NONE;
		limit = (slot_ticks_q == '0) ? 32'd1 : {8'd0, slot_ticks_q};

		case (op)
			OP_TICK: if (mode_q != MODE_IDLE) begin
				ticks_q = ticks_q + 32'd1;
				if (ticks_q >= limit) begin
					ticks_q = 32'd0;
					if (mode_q == MODE_SINGLE) begin
						slot_q = slot_q + 3'd1;
						if (slot_q >= ((digits_q[scan_q] == DIGIT_POINT) ? 3'd1 : SLOTS)) begin
							slot_q = 3'd0;
							mode_q = MODE_IDLE;
							w.st = STATUS_FINISHED;
						end
					end else if (point_phase_q) begin
						point_phase_q = 1'b0;
						scan_q = LAST_DIGIT;
						slot_q = 3'd0;
					end else begin
						slot_q = slot_q + 3'd1;
						if (slot_q >= SLOTS) begin
							slot_q = 3'd0;
							if (scan_q > 2'd0) begin
								scan_q = scan_q - 2'd1;
							end else begin
								if (refresh_q > '0) refresh_q = refresh_q - 16'd1;
								if (refresh_q == '0) begin
									mode_q = MODE_IDLE;
									scan_q = 2'd0;
									w.st = STATUS_FINISHED;
								end else begin
									restart_scan();
								end
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (mode_q != MODE_IDLE) begin
					w.st = STATUS_REFUSED;
				end else if (v > MAX_THOUSANDTHS) begin
					w.st = STATUS_RANGE;
				end else begin
					whole = v / 1000;
					k = 1;
					while (k < 10 && whole >= pow10(k)) k++;
					if (k < 4) begin
						shown = (longint'(v) * pow10(4 - k)) / 1000;
						point_pos_q = 3'(k);
					end else begin
						shown = whole;
						point_pos_q = 3'd0;
					end
					for (i = 3; i >= 0; i--) begin
						digits_q[i] = 4'(shown % 10);
						shown = shown / 10;
					end
					refresh_q = rate_q * sec;
					if (refresh_q == '0) begin
						w.st = STATUS_FINISHED;
					end else begin
						mode_q = MODE_VALUE;
						restart_scan();
						w.st = STATUS_ACCEPTED;
					end
				end
			end
			OP_DIGIT: begin
				if (mode_q != MODE_IDLE) begin
					w.st = STATUS_REFUSED;
				end else if (dv > DIGIT_POINT || pos < 3'd1 || pos > DIGITS) begin
					w.st = STATUS_RANGE;
				end else begin
					scan_q = 2'(pos - 3'd1);
					digits_q[scan_q] = dv;
					slot_q = 3'd0;
					ticks_q = 32'd0;
					point_phase_q = 1'b0;
					mode_q = MODE_SINGLE;
					w.st = STATUS_ACCEPTED;
				end
			end
			default: ;
		endcase
		w.busy = (mode_q != MODE_IDLE);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pin_word_t want;
		pin_word_t got;
		if (!arst_n) begin
			pol_q = 1'b0;
			slot_ticks_q = SLOT_TICKS_RST;
			rate_q = RATE_RST;
			foreach (digits_q[j]) digits_q[j] = '0;
			point_pos_q = 3'd0;
			scan_q = 2'd0;
			slot_q = 3'd0;
			ticks_q = 32'd0;
			refresh_q = '0;
			mode_q = MODE_IDLE;
			point_phase_q = 1'b0;
			pin_words.delete();
			errors = 0;
			fail_count <= '0;
			pending <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_POLARITY:   pol_q = cfg_wdata[0];
					REG_SLOT_TICKS: slot_ticks_q = cfg_wdata;
					REG_RATE:       rate_q = cfg_wdata[RATE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {segment_lines, digit_lines, busy_res, status};
				if (pin_words.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("unexpected result word: seg %h dig %h busy %b status %0d",
							got.seg, got.dig, got.busy, got.st);
					errors++;
				end else begin
					want = pin_words.pop_front();
					if (want != got) begin
						if (errors < REPORT_MAX)
							$display("mismatch exp/act: seg %h/%h dig %h/%h busy %b/%b status %0d/%0d",
								want.seg, got.seg, want.dig, got.dig, want.busy, got.busy,
								want.st, got.st);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_pins(opcode, value_thousandths, display_seconds, digit_value,
					digit_position, want);
				pin_words.push_back(want);
			end
			fail_count <= errors;
			pending <= pin_words.size();
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_seven_segment_scan_driver_unit.sv @@
// Top of the scan driver testbench: clock, reset, register setup and input word traffic
// with bursty sending and receiver stalls; ssd_scoreboard does prediction and comparison.
// Depends on ssd_pkg, seven_segment_scan_driver_unit and ssd_scoreboard.
`default_nettype none

module tb_seven_segment_scan_driver_unit
	import ssd_pkg::*;
;

	localparam opcode_t                OP_RSVD     = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED  = 2'd3;
	localparam int                     SETTLE      = 16;
	localparam int                     CYCLE_LIMIT = 400000;
	localparam int                     RX_OPEN     = 0;
	localparam int                     RX_RANDOM   = 1;
	localparam int                     RX_PERIODIC = 2;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [OPCODE_W-1:0]    opcode = '0;
	logic [VALUE_W-1:0]     value_thousandths = '0;
	logic [SEC_W-1:0]       display_seconds = '0;
	logic [DIGIT_W-1:0]     digit_value = '0;
	logic [POS_W-1:0]       digit_position = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SEG_W-1:0]       segment_lines;
	logic [DIGLINE_W-1:0]   digit_lines;
	logic                   busy_res;
	logic [STATUS_W-1:0]    status;
	logic [31:0]            fail_count;
	logic [31:0]            pending;

	int cycle_count = 0;
	int rx_mode = RX_OPEN;
	int rx_left = 0;

	seven_segment_scan_driver_unit dut (.*);

	ssd_scoreboard u_scoreboard (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(RX_OPEN, RX_PERIODIC);
			rx_left <= $urandom_range(20, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default:   out_ready <= rx_left[1];
		endcase
	end

	task automatic push_word(input opcode_t op, input logic [VALUE_W-1:0] v,
			input logic [SEC_W-1:0] sec, input logic [DIGIT_W-1:0] dv,
			input logic [POS_W-1:0] pos);
		in_valid <= 1'b1;
		opcode <= op;
		value_thousandths <= v;
		display_seconds <= sec;
		digit_value <= dv;
		digit_position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic apply_setting(input logic pol, input logic [CFG_DATA_W-1:0] slots,
			input logic [RATE_W-1:0] rate);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_POLARITY;
		cfg_wdata <= {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)} | CFG_DATA_W'(pol);
		@(posedge clk);
		cfg_index <= REG_SLOT_TICKS;
		cfg_wdata <= slots;
		@(posedge clk);
		cfg_index <= REG_RATE;
		cfg_wdata <= {16'($urandom), rate};
		@(posedge clk);
		cfg_index <= REG_UNUSED;
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly ticks, then loads (some out of range) and well-formed digits, the rest malformed words
	task automatic send_random(input int count, input bit gaps, input int sec_max);
		int burst_left;
		int pick;
		logic [VALUE_W-1:0] v;
		burst_left = $urandom_range(1, 24);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 4))
				0:       v = VALUE_W'($urandom_range(0, 9999));
				1:       v = VALUE_W'($urandom_range(10000, 99999));
				2:       v = VALUE_W'($urandom_range(100000, 999999));
				3:       v = VALUE_W'($urandom_range(1000000, MAX_THOUSANDTHS));
				default: v = VALUE_W'($urandom_range(MAX_THOUSANDTHS + 1, 24'hFFFFFF));
			endcase
			if (pick < 78) begin
				push_word(OP_TICK, VALUE_W'($urandom), SEC_W'($urandom), DIGIT_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 86) begin
				push_word(OP_LOAD, v, SEC_W'($urandom_range(0, sec_max)), DIGIT_W'($urandom),
					POS_W'($urandom));
			end else if (pick < 93) begin
				push_word(OP_DIGIT, VALUE_W'($urandom), SEC_W'($urandom),
					DIGIT_W'($urandom_range(0, 10)), POS_W'($urandom_range(1, 4)));
			end else begin
				case ($urandom_range(0, 3))
					0: push_word(OP_RSVD, VALUE_W'($urandom), SEC_W'($urandom),
						DIGIT_W'($urandom), POS_W'($urandom));
					1: push_word(OP_LOAD, VALUE_W'($urandom_range(MAX_THOUSANDTHS + 1, 24'hFFFFFF)),
						SEC_W'($urandom), DIGIT_W'($urandom), POS_W'($urandom));
					2: push_word(OP_DIGIT, VALUE_W'($urandom), SEC_W'($urandom),
						DIGIT_W'($urandom_range(11, 15)), POS_W'($urandom));
					default: push_word(OP_DIGIT, VALUE_W'($urandom), SEC_W'($urandom),
						DIGIT_W'($urandom_range(0, 10)),
						($urandom_range(0, 1) != 0) ? POS_W'(0) : POS_W'($urandom_range(5, 7)));
				endcase
			end
			if ($urandom_range(0, 199) == 0) drain_results();
			if (gaps) begin
				burst_left--;
				if (burst_left == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
					burst_left = $urandom_range(1, 24);
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(OP_RSVD, '1, '1, '1, '1);
		push_word(OP_TICK, '0, '0, '0, '0);
		push_word(OP_LOAD, MAX_THOUSANDTHS + 24'd1, 8'd1, 4'd0, 3'd0);

		apply_setting(1'b0, 24'd1, 8'd1);
		push_word(OP_LOAD, 24'hFFFFFF, 8'd1, 4'd0, 3'd0);
		push_word(OP_DIGIT, '0, '0, 4'd11, 3'd1);
		push_word(OP_DIGIT, '0, '0, 4'd15, 3'd7);
		push_word(OP_DIGIT, '0, '0, 4'd3, 3'd0);
		push_word(OP_DIGIT, '0, '0, 4'd3, 3'd5);
		push_word(OP_LOAD, 24'd5000, 8'd0, 4'd0, 3'd0);
		push_word(OP_DIGIT, '0, '0, DIGIT_POINT, 3'd1);
		push_word(OP_TICK, '0, '0, '0, '0);
		push_word(OP_DIGIT, '0, '0, 4'd8, 3'd4);
		push_word(OP_LOAD, 24'd1234, 8'd1, 4'd0, 3'd0);
		push_word(OP_DIGIT, '0, '0, 4'd5, 3'd2);
		repeat (7) push_word(OP_TICK, '0, '0, '0, '0);
		push_word(OP_LOAD, MAX_THOUSANDTHS, 8'd1, 4'd0, 3'd0);
		push_word(OP_LOAD, 24'd0, 8'd1, 4'd0, 3'd0);

		apply_setting(1'b1, 24'd1, 8'd1);
		send_random(180, 1'b1, 2);
		apply_setting(1'b0, 24'd2, 8'd2);
		send_random(180, 1'b0, 2);
		apply_setting(1'b1, 24'd0, 8'd1);
		send_random(180, 1'b1, 2);
		apply_setting(1'b0, 24'd3, 8'd1);
		send_random(180, 1'b1, 2);
		apply_setting(1'b1, 24'd1, 8'd3);
		send_random(120, 1'b1, 2);

		apply_setting(1'b1, 24'hFFFFFF, 8'hFF);
		push_word(OP_LOAD, 24'd12345, 8'd0, 4'd0, 3'd0);
		push_word(OP_LOAD, 24'd987654, 8'hFF, 4'd0, 3'd0);
		send_random(40, 1'b1, 255);

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
